// ----- rtl/nrpp_pkg.sv -----
// shared types and constants of the nmea rmc/gga position parser
package nrpp_pkg;

    localparam int FRACTION_DIGITS = 5;
    localparam int WHOLE_W  = 32;
    localparam int FRAC_W   = 17;
    localparam int CNT_W    = 3;
    localparam int FIELD_W  = 5;
    localparam int FLAG_W   = 8;
    localparam int STAT_W   = 3;
    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int SATS_W   = 8;
    localparam int ALT_W    = 21;
    localparam int PREFIX_LEN  = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_DOT   = 8'd46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_A     = 8'd65;
    localparam logic [7:0] CH_S     = 8'd83;
    localparam logic [7:0] CH_W     = 8'd87;

    localparam logic [7:0] PREFIX_TEXT [0:2][0:PREFIX_LEN-1] = '{
        '{"$", "G", "P", "R", "M", "C"},
        '{"$", "G", "P", "G", "G", "A"},
        '{"$", "G", "N", "G", "G", "A"}
    };

    localparam logic [FIELD_W-1:0] FLD_STATUS = 5'd2;
    localparam logic [FIELD_W-1:0] FLD_LAT    = 5'd3;
    localparam logic [FIELD_W-1:0] FLD_NS     = 5'd4;
    localparam logic [FIELD_W-1:0] FLD_LON    = 5'd5;
    localparam logic [FIELD_W-1:0] FLD_EW     = 5'd6;
    localparam logic [FIELD_W-1:0] FLD_SATS   = 5'd7;
    localparam logic [FIELD_W-1:0] FLD_ALT    = 5'd9;
    localparam logic [FIELD_W-1:0] FLD_MAX    = 5'd31;

    localparam logic [23:0] POW10 [0:7] = '{
        24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000,
        24'd1000000, 24'd10000000
    };

    localparam longint unsigned SCALE      = 64'(10 ** FRACTION_DIGITS);
    localparam longint unsigned DEG_UNIT   = 64'd10000000;
    localparam int              MINS_W     = $clog2(100 * SCALE);
    localparam longint unsigned MINS_DIV   = 64'd60 * SCALE;
    localparam longint unsigned MINS_RECIP = ((64'd1 << MINS_W) * DEG_UNIT) / MINS_DIV;
    localparam longint unsigned DEG_RECIP  = (64'd1 << 32) / 64'd100;
    localparam int              DEG_W      = 26;
    localparam int              MQ_W       = 25;
    localparam int              MAG_W      = 50;
    localparam int              PROD_W     = MINS_W + 24;

    localparam logic [31:0]      LAT_LIMIT  = 32'd900000000;
    localparam logic [31:0]      LON_LIMIT  = 32'd1800000000;
    localparam logic [ALT_W-1:0] ALT_HI     = 21'd999999;
    localparam logic [ALT_W-1:0] ALT_LO_MAG = 21'd99999;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_RMC   = 2'd1,
        KIND_GGA   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        FIN_NONE = 3'd0,
        FIN_LAT  = 3'd1,
        FIN_LON  = 3'd2,
        FIN_SATS = 3'd3,
        FIN_ALT  = 3'd4
    } fin_t;

    // one queue entry: a finished numeric field and, on a line end, the line summary
    typedef struct packed {
        fin_t              fin;
        logic              neg;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0] frac;
        logic [CNT_W-1:0]  cnt;
        logic [3:0]        fdig;
        logic              eol;
        kind_t             kind;
        logic [FLAG_W-1:0] flags;
        logic [STAT_W-1:0] status;
    } event_t;

endpackage

// ----- rtl/nrpp_fifo.sv -----
// small register queue between the character front end and the conversion back end
module nrpp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/nrpp_front.sv -----
// character front end: line assembly, prefix match, field tracking and number scanning
module nrpp_front
    import nrpp_pkg::*;
#(
    parameter int LINE_LIMIT  = 256,
    parameter int PARSE_LIMIT = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       q_full,
    output logic       q_push,
    output event_t     q_event
);

    localparam int POS_W = $clog2(LINE_LIMIT);
    localparam int CMP_W = 9;

    typedef enum logic [3:0] {
        NUM_LEAD  = 4'b0001,
        NUM_WHOLE = 4'b0010,
        NUM_FRAC  = 4'b0100,
        NUM_DONE  = 4'b1000
    } num_state_t;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [FIELD_W-1:0] field_reg, field_next;
    kind_t              kind_reg, kind_next;
    logic [2:0]         mask_reg, mask_next;
    logic [FLAG_W-1:0]  flags_reg, flags_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               closed_reg, closed_next;
    num_state_t         num_reg, num_next;
    logic               neg_reg, neg_next;
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [3:0]         fdig_reg, fdig_next;

    logic        accept, is_digit, is_blank, skip;
    logic [7:0]  c;
    logic [3:0]  d;
    logic [35:0] w10;
    num_state_t  num_eff;
    fin_t        fin_cur;
    logic [2:0]  flag_idx;

    assign s_ready  = !q_full;
    assign accept   = s_valid && !q_full;
    assign c        = s_rx_byte;
    assign d        = c[3:0];
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    assign w10      = ({4'b0, whole_reg} << 3) + ({4'b0, whole_reg} << 1) + 36'(d);
    assign flag_idx = 3'(field_reg - FLD_STATUS);

    always_comb begin
        unique case (field_reg)
            FLD_LAT:  fin_cur = FIN_LAT;
            FLD_LON:  fin_cur = FIN_LON;
            FLD_SATS: fin_cur = FIN_SATS;
            FLD_ALT:  fin_cur = FIN_ALT;
            default:  fin_cur = FIN_NONE;
        endcase
    end

    always_comb begin
        pos_next    = pos_reg;
        field_next  = field_reg;
        kind_next   = kind_reg;
        mask_next   = mask_reg;
        flags_next  = flags_reg;
        status_next = status_reg;
        closed_next = closed_reg;
        num_next    = num_reg;
        neg_next    = neg_reg;
        whole_next  = whole_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        fdig_next   = fdig_reg;
        skip        = 1'b0;
        num_eff     = num_reg;

        q_push         = 1'b0;
        q_event.fin    = fin_cur;
        q_event.neg    = neg_reg;
        q_event.whole  = whole_reg;
        q_event.frac   = frac_reg;
        q_event.cnt    = cnt_reg;
        q_event.fdig   = fdig_reg;
        q_event.eol    = 1'b0;
        q_event.kind   = kind_reg;
        q_event.flags  = flags_reg;
        q_event.status = status_reg;

        if (accept && c != CH_CR) begin
            if (c == CH_LF) begin
                q_push      = 1'b1;
                q_event.eol = 1'b1;
            end
            if (c == CH_LF || pos_reg >= POS_W'(LINE_LIMIT - 1)) begin
                // line done or overlong: start a fresh line
                pos_next    = '0;
                field_next  = '0;
                kind_next   = KIND_OTHER;
                mask_next   = 3'b111;
                flags_next  = '0;
                status_next = '0;
                closed_next = 1'b0;
                num_next    = NUM_LEAD;
                neg_next    = 1'b0;
                whole_next  = '0;
                frac_next   = '0;
                cnt_next    = '0;
                fdig_next   = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (!closed_reg && CMP_W'(pos_reg) < CMP_W'(PARSE_LIMIT - 1)) begin
                    if (c == CH_NUL) begin
                        closed_next = 1'b1;
                    end else begin
                        if (pos_reg < POS_W'(PREFIX_LEN)) begin
                            for (int k = 0; k < 3; k++) begin
                                if (PREFIX_TEXT[k][pos_reg[2:0]] != c) begin
                                    mask_next[k] = 1'b0;
                                end
                            end
                            if (pos_reg == POS_W'(PREFIX_LEN - 1)) begin
                                if (mask_next[0]) begin
                                    kind_next = KIND_RMC;
                                end else if (mask_next[2:1] != 2'b00) begin
                                    kind_next = KIND_GGA;
                                end else begin
                                    kind_next = KIND_OTHER;
                                end
                            end
                        end
                        if (c == CH_COMMA) begin
                            q_push     = (fin_cur != FIN_NONE);
                            num_next   = NUM_LEAD;
                            neg_next   = 1'b0;
                            whole_next = '0;
                            frac_next  = '0;
                            cnt_next   = '0;
                            fdig_next  = '0;
                            if (field_reg != FLD_MAX) begin
                                field_next = field_reg + 1'b1;
                            end
                        end else begin
                            if (field_reg >= FLD_STATUS && field_reg <= FLD_ALT
                                    && !flags_reg[flag_idx]) begin
                                flags_next[flag_idx] = 1'b1;
                                if (field_reg == FLD_STATUS && c == CH_A) status_next[0] = 1'b1;
                                if (field_reg == FLD_NS && c == CH_S) status_next[1] = 1'b1;
                                if (field_reg == FLD_EW && c == CH_W) status_next[2] = 1'b1;
                            end
                            // number scanner
                            if (num_reg == NUM_LEAD) begin
                                if (is_blank) begin
                                    skip = 1'b1;
                                end else if (c == CH_PLUS) begin
                                    skip     = 1'b1;
                                    num_next = NUM_WHOLE;
                                end else if (c == CH_MINUS) begin
                                    skip     = 1'b1;
                                    neg_next = 1'b1;
                                    num_next = NUM_WHOLE;
                                end else begin
                                    num_eff  = NUM_WHOLE;
                                    num_next = NUM_WHOLE;
                                end
                            end
                            if (!skip) begin
                                unique case (num_eff)
                                    NUM_WHOLE: begin
                                        if (is_digit) begin
                                            whole_next = (w10 > 36'hFFFF_FFFF) ? '1 : w10[31:0];
                                        end else if (c == CH_DOT) begin
                                            num_next = NUM_FRAC;
                                        end else begin
                                            num_next = NUM_DONE;
                                        end
                                    end
                                    NUM_FRAC: begin
                                        if (is_digit) begin
                                            if (cnt_reg < CNT_W'(FRACTION_DIGITS)) begin
                                                frac_next = frac_reg * 17'd10 + FRAC_W'(d);
                                                cnt_next  = cnt_reg + 1'b1;
                                                if (cnt_reg == '0) fdig_next = d;
                                            end
                                        end else begin
                                            num_next = NUM_DONE;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            field_reg  <= '0;
            kind_reg   <= KIND_OTHER;
            mask_reg   <= 3'b111;
            flags_reg  <= '0;
            status_reg <= '0;
            closed_reg <= 1'b0;
            num_reg    <= NUM_LEAD;
            neg_reg    <= 1'b0;
            whole_reg  <= '0;
            frac_reg   <= '0;
            cnt_reg    <= '0;
            fdig_reg   <= '0;
        end else begin
            pos_reg    <= pos_next;
            field_reg  <= field_next;
            kind_reg   <= kind_next;
            mask_reg   <= mask_next;
            flags_reg  <= flags_next;
            status_reg <= status_next;
            closed_reg <= closed_next;
            num_reg    <= num_next;
            neg_reg    <= neg_next;
            whole_reg  <= whole_next;
            frac_reg   <= frac_next;
            cnt_reg    <= cnt_next;
            fdig_reg   <= fdig_next;
        end
    end

endmodule

// ----- rtl/nrpp_back.sv -----
// conversion back end: coordinate pipeline, held telemetry and the result register
module nrpp_back
    import nrpp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  event_t                  q_data,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_sentence_kind,
    output logic                    m_fix_valid,
    output logic                    m_position_updated,
    output logic signed [LAT_W-1:0] m_latitude,
    output logic signed [LON_W-1:0] m_longitude,
    output logic [SATS_W-1:0]       m_num_sats,
    output logic signed [ALT_W-1:0] m_altitude_dm
);

    typedef struct packed {
        event_t              ev;
        logic [MINS_W-1:0]   fs;
        logic [DEG_W-1:0]    deg;
        logic [6:0]          rem;
        logic [MINS_W-1:0]   mins;
        logic [MAG_W-1:0]    degm;
        logic [PROD_W-1:0]   prodm;
        logic [MQ_W-1:0]     qm;
        logic [MAG_W-1:0]    mag;
    } work_t;

    work_t      w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;
    work_t      w1_next, w2_next, w3_next, w4_next, w5_next;
    logic [4:0] v_reg;
    logic       adv;

    logic signed [LAT_W-1:0] pend_lat_reg, pend_lat_next, held_lat_reg, held_lat_next;
    logic signed [LON_W-1:0] pend_lon_reg, pend_lon_next, held_lon_reg, held_lon_next;
    logic [SATS_W-1:0]       pend_sats_reg, pend_sats_next, held_sats_reg, held_sats_next;
    logic signed [ALT_W-1:0] pend_alt_reg, pend_alt_next, held_alt_reg, held_alt_next;
    logic                    held_fix_reg, held_fix_next;
    logic                    m_valid_reg;
    kind_t                   kind_reg;
    logic                    upd_reg, upd_next;

    logic [32:0]             r2;
    logic [PROD_W-1:0]       rr;
    logic [31:0]             lim, magc;
    logic signed [32:0]      coord;
    logic [ALT_W-1:0]        a10, amag;
    logic [3:0]              fd;

    // pipeline only holds while a line result waits on a full output
    assign adv   = !(v_reg[4] && w5_reg.ev.eol && m_valid_reg && !m_ready);
    assign q_pop = adv && !q_empty;

    always_comb begin
        // degrees estimate and scaled fraction
        w1_next      = '0;
        w1_next.ev   = q_data;
        w1_next.fs   = MINS_W'(64'(q_data.frac) *
                               64'(POW10[CNT_W'(FRACTION_DIGITS) - q_data.cnt]));
        w1_next.deg  = DEG_W'((64'(q_data.whole) * DEG_RECIP) >> 32);

        // correct degrees, split off whole minutes
        w2_next = w1_reg;
        r2 = {1'b0, w1_reg.ev.whole} - 33'(64'(w1_reg.deg) * 64'd100);
        if (r2 >= 33'd100) begin
            w2_next.deg = w1_reg.deg + 1'b1;
            w2_next.rem = 7'(r2 - 33'd100);
        end else begin
            w2_next.rem = r2[6:0];
        end

        w3_next      = w2_reg;
        w3_next.mins = MINS_W'(64'(w2_reg.rem) * SCALE) + w2_reg.fs;
        w3_next.degm = MAG_W'(64'(w2_reg.deg) * DEG_UNIT);

        // minutes to degree units by reciprocal estimate
        w4_next       = w3_reg;
        w4_next.qm    = MQ_W'((64'(w3_reg.mins) * MINS_RECIP) >> MINS_W);
        w4_next.prodm = PROD_W'(64'(w3_reg.mins) * DEG_UNIT);

        w5_next = w4_reg;
        rr = w4_reg.prodm - PROD_W'(64'(w4_reg.qm) * MINS_DIV);
        w5_next.qm  = (rr >= PROD_W'(MINS_DIV)) ? w4_reg.qm + 1'b1 : w4_reg.qm;
        w5_next.mag = w4_reg.degm + MAG_W'(w5_next.qm);
    end

    always_comb begin
        lim   = (w5_reg.ev.fin == FIN_LAT) ? LAT_LIMIT : LON_LIMIT;
        magc  = (w5_reg.mag > MAG_W'(lim)) ? lim : w5_reg.mag[31:0];
        coord = w5_reg.ev.neg ? -$signed({1'b0, magc}) : $signed({1'b0, magc});

        fd   = (w5_reg.ev.cnt != '0) ? w5_reg.ev.fdig : 4'd0;
        a10  = ALT_W'(w5_reg.ev.whole) * 21'd10 + ALT_W'(fd);
        amag = (w5_reg.ev.whole > 32'(ALT_LO_MAG)) ? ALT_HI : a10;

        pend_lat_next  = pend_lat_reg;
        pend_lon_next  = pend_lon_reg;
        pend_sats_next = pend_sats_reg;
        pend_alt_next  = pend_alt_reg;
        unique case (w5_reg.ev.fin)
            FIN_LAT:  pend_lat_next = LAT_W'(coord);
            FIN_LON:  pend_lon_next = LON_W'(coord);
            FIN_SATS: begin
                if (w5_reg.ev.neg) begin
                    pend_sats_next = '0;
                end else begin
                    pend_sats_next = (w5_reg.ev.whole > 32'd255) ? '1 : w5_reg.ev.whole[7:0];
                end
            end
            FIN_ALT: begin
                if (!w5_reg.ev.neg) begin
                    pend_alt_next = $signed(amag);
                end else if (amag > ALT_LO_MAG) begin
                    pend_alt_next = -$signed(ALT_LO_MAG);
                end else begin
                    pend_alt_next = -$signed(amag);
                end
            end
            default: ;
        endcase

        held_fix_next  = held_fix_reg;
        held_lat_next  = held_lat_reg;
        held_lon_next  = held_lon_reg;
        held_sats_next = held_sats_reg;
        held_alt_next  = held_alt_reg;
        upd_next       = 1'b0;
        unique case (w5_reg.ev.kind)
            KIND_RMC: begin
                held_fix_next = w5_reg.ev.flags[0] && w5_reg.ev.status[0];
                if (held_fix_next && w5_reg.ev.flags[4:1] == 4'hF) begin
                    held_lat_next = w5_reg.ev.status[1] ? -pend_lat_next : pend_lat_next;
                    held_lon_next = w5_reg.ev.status[2] ? -pend_lon_next : pend_lon_next;
                    upd_next      = 1'b1;
                end
            end
            KIND_GGA: begin
                held_sats_next = w5_reg.ev.flags[5] ? pend_sats_next : '0;
                held_alt_next  = w5_reg.ev.flags[7] ? pend_alt_next : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg         <= '0;
            m_valid_reg   <= 1'b0;
            kind_reg      <= KIND_OTHER;
            upd_reg       <= 1'b0;
            pend_lat_reg  <= '0;
            pend_lon_reg  <= '0;
            pend_sats_reg <= '0;
            pend_alt_reg  <= '0;
            held_fix_reg  <= 1'b0;
            held_lat_reg  <= '0;
            held_lon_reg  <= '0;
            held_sats_reg <= '0;
            held_alt_reg  <= '0;
        end else begin
            if (adv) begin
                v_reg <= {v_reg[3:0], !q_empty};
                if (v_reg[4]) begin
                    pend_lat_reg  <= pend_lat_next;
                    pend_lon_reg  <= pend_lon_next;
                    pend_sats_reg <= pend_sats_next;
                    pend_alt_reg  <= pend_alt_next;
                end
            end
            if (adv && v_reg[4] && w5_reg.ev.eol) begin
                m_valid_reg   <= 1'b1;
                kind_reg      <= w5_reg.ev.kind;
                upd_reg       <= upd_next;
                held_fix_reg  <= held_fix_next;
                held_lat_reg  <= held_lat_next;
                held_lon_reg  <= held_lon_next;
                held_sats_reg <= held_sats_next;
                held_alt_reg  <= held_alt_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w1_reg <= w1_next;
            w2_reg <= w2_next;
            w3_reg <= w3_next;
            w4_reg <= w4_next;
            w5_reg <= w5_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_sentence_kind    = kind_reg;
    assign m_fix_valid        = held_fix_reg;
    assign m_position_updated = upd_reg;
    assign m_latitude         = held_lat_reg;
    assign m_longitude        = held_lon_reg;
    assign m_num_sats         = held_sats_reg;
    assign m_altitude_dm      = held_alt_reg;

endmodule

// ----- rtl/nmea_rmc_gga_position_parser.sv -----
// Top level of the NMEA RMC/GGA position parser. One received byte is taken per cycle
// (s_ready drops only when the four-entry queue between the character front end and the
// conversion back end is full, which happens only while a line result waits on m_ready).
// Every line feed gives one result, with m_valid rising once the line feed has passed
// through the queue and the five-stage coordinate conversion pipeline; all other
// bytes give none. Latitude and longitude are in 1e-7 degrees, altitude in 0.1 m.
module nmea_rmc_gga_position_parser
    import nrpp_pkg::*;
#(
    parameter int LINE_LIMIT  = 256,
    parameter int PARSE_LIMIT = 128
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_rx_byte,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_sentence_kind,
    output logic                    m_fix_valid,
    output logic                    m_position_updated,
    output logic signed [LAT_W-1:0] m_latitude,
    output logic signed [LON_W-1:0] m_longitude,
    output logic [SATS_W-1:0]       m_num_sats,
    output logic signed [ALT_W-1:0] m_altitude_dm
);

    localparam int EV_W = $bits(event_t);

    logic   q_full, q_push, q_empty, q_pop;
    event_t q_wr_event, q_rd_event;
    logic [EV_W-1:0] q_rd_bits;

    nrpp_front #(
        .LINE_LIMIT  (LINE_LIMIT),
        .PARSE_LIMIT (PARSE_LIMIT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_event   (q_wr_event)
    );

    nrpp_fifo #(
        .WIDTH (EV_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wr_event),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rd_bits),
        .empty   (q_empty)
    );

    assign q_rd_event = event_t'(q_rd_bits);

    nrpp_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_empty            (q_empty),
        .q_data             (q_rd_event),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sentence_kind    (m_sentence_kind),
        .m_fix_valid        (m_fix_valid),
        .m_position_updated (m_position_updated),
        .m_latitude         (m_latitude),
        .m_longitude        (m_longitude),
        .m_num_sats         (m_num_sats),
        .m_altitude_dm      (m_altitude_dm)
    );

endmodule

// ----- tb/nmea_rmc_gga_position_parser_tb.sv -----
// self-checking testbench for the nmea rmc/gga position parser
module nmea_rmc_gga_position_parser_tb;
    import nrpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_MAX  = 256;
    localparam int PARSE_MAX = 128;
    localparam int FDIG      = 5;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        kind_t                   kind;
        logic                    fix;
        logic                    upd;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        logic [SATS_W-1:0]       sats;
        logic signed [ALT_W-1:0] alt;
    } fix_report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [7:0] s_rx_byte = 8'd0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_sentence_kind;
    logic m_fix_valid;
    logic m_position_updated;
    logic signed [LAT_W-1:0] m_latitude;
    logic signed [LON_W-1:0] m_longitude;
    logic [SATS_W-1:0] m_num_sats;
    logic signed [ALT_W-1:0] m_altitude_dm;

    nmea_rmc_gga_position_parser dut (.*);

    always #5 aclk = ~aclk;

    logic [7:0]  byte_queue [$];
    fix_report_t report_queue [$];
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_send = 1'b0;
    bit  failed = 1'b0;
    longint cycles = 0;

    // predictor state
    int unsigned ln_pos, fld_num, pfx_kind, pfx_mask;
    longint unsigned whole_acc, frac_acc, frac_cnt;
    int unsigned present, stat_hemi, num_phase;
    bit num_neg, closed;
    longint pend_lat, pend_lon, pend_sats, pend_alt;
    longint h_lat, h_lon, h_alt;
    int unsigned h_sats, h_fix;

    function automatic longint unsigned p10(int n);
        longint unsigned r;
        r = 1;
        repeat (n) r *= 10;
        return r;
    endfunction

    function automatic void number_reset();
        whole_acc = 0; frac_acc = 0; frac_cnt = 0; num_phase = 0; num_neg = 0;
    endfunction

    function automatic void line_reset();
        ln_pos = 0; fld_num = 0; pfx_kind = KIND_OTHER; pfx_mask = 7;
        present = 0; stat_hemi = 0; closed = 0;
        number_reset();
    endfunction

    function automatic void number_take(logic [7:0] c);
        bit dig;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        if (num_phase == 0) begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) return;
            if (c == CH_PLUS) begin num_phase = 1; return; end
            if (c == CH_MINUS) begin num_neg = 1; num_phase = 1; return; end
            num_phase = 1;
        end
        if (num_phase == 1) begin
            if (dig) begin
                whole_acc = whole_acc * 10 + (c - CH_ZERO);
                if (whole_acc > 64'hFFFF_FFFF) whole_acc = 64'hFFFF_FFFF;
            end else if (c == CH_DOT) num_phase = 2;
            else num_phase = 3;
        end else if (num_phase == 2) begin
            if (dig) begin
                if (frac_cnt < FDIG) begin
                    frac_acc = frac_acc * 10 + (c - CH_ZERO);
                    frac_cnt++;
                end
            end else num_phase = 3;
        end
    endfunction

    function automatic longint signed_clamp(longint unsigned mag, longint unsigned lim);
        longint v;
        v = (mag > lim) ? lim : mag;
        return num_neg ? -v : v;
    endfunction

    function automatic longint coord_of(longint unsigned lim);
        longint unsigned sc, mins, mag;
        sc = p10(FDIG);
        mins = (whole_acc % 100) * sc + frac_acc * p10(FDIG - frac_cnt);
        mag = (whole_acc / 100) * 64'd10000000 + mins * 64'd10000000 / (60 * sc);
        return signed_clamp(mag, lim);
    endfunction

    function automatic void close_field();
        longint unsigned mag;
        longint v;
        case (fld_num)
            FLD_LAT: pend_lat = coord_of(900000000);
            FLD_LON: pend_lon = coord_of(1800000000);
            FLD_SATS: pend_sats = num_neg ? 0 : (whole_acc > 255 ? 255 : whole_acc);
            FLD_ALT: begin
                mag = (whole_acc * p10(FDIG) + frac_acc * p10(FDIG - frac_cnt))
                      / p10(FDIG - 1);
                v = signed_clamp(mag, 999999);
                pend_alt = v < -99999 ? -99999 : v;
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        int unsigned p, f;
        fix_report_t r;
        bit upd;
        upd = 0;
        if (c == CH_CR) return;
        if (c == CH_LF) begin
            close_field();
            if (pfx_kind == KIND_RMC) begin
                h_fix = present[0] ? stat_hemi[0] : 0;
                if (h_fix != 0 && (present & 'h1E) == 'h1E) begin
                    h_lat = stat_hemi[1] ? -pend_lat : pend_lat;
                    h_lon = stat_hemi[2] ? -pend_lon : pend_lon;
                    upd = 1;
                end
            end else if (pfx_kind == KIND_GGA) begin
                h_sats = present[5] ? pend_sats : 0;
                h_alt = present[7] ? pend_alt : 0;
            end
            r.kind = kind_t'(pfx_kind);
            r.fix = h_fix[0];
            r.upd = upd;
            r.lat = h_lat[LAT_W-1:0];
            r.lon = h_lon[LON_W-1:0];
            r.sats = h_sats[7:0];
            r.alt = h_alt[ALT_W-1:0];
            report_queue.push_back(r);
            line_reset();
            return;
        end
        if (ln_pos >= LINE_MAX - 1) begin line_reset(); return; end
        p = ln_pos++;
        if (closed || p >= PARSE_MAX - 1) return;
        if (c == CH_NUL) begin
            closed = 1;
            if (p < PREFIX_LEN) pfx_mask = 0;
            return;
        end
        if (p < PREFIX_LEN) begin
            for (int k = 0; k < 3; k++)
                if (PREFIX_TEXT[k][p] != c) pfx_mask &= ~(1 << k);
            if (p == PREFIX_LEN - 1)
                pfx_kind = pfx_mask[0] ? KIND_RMC : ((pfx_mask & 6) ? KIND_GGA : KIND_OTHER);
        end
        if (c == CH_COMMA) begin
            close_field();
            number_reset();
            if (fld_num < FLD_MAX) fld_num++;
            return;
        end
        f = fld_num;
        if (f >= 2 && f <= 9 && !present[f-2]) begin
            present |= 1 << (f - 2);
            if (f == FLD_STATUS && c == CH_A) stat_hemi |= 1;
            if (f == FLD_NS && c == CH_S) stat_hemi |= 2;
            if (f == FLD_EW && c == CH_W) stat_hemi |= 4;
        end
        number_take(c);
    endfunction

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_byte(s_rx_byte);
                void'(byte_queue.pop_front());
            end
            if (s_valid && !s_ready) begin
            end else if (byte_queue.size() > (s_valid && s_ready ? 1 : 0) && !hold_send
                         && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_rx_byte <= byte_queue[(s_valid && s_ready) ? 1 : 0];
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        fix_report_t e;
        if (aresetn && m_valid && m_ready) begin
            if (report_queue.size() == 0) begin
                $display("%0t: unexpected result kind %0d", $time, m_sentence_kind);
                failed = 1'b1;
            end else begin
                e = report_queue.pop_front();
                if (m_sentence_kind !== e.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, e.kind, m_sentence_kind);
                    failed = 1'b1;
                end
                if (m_fix_valid !== e.fix) begin
                    $display("%0t: fix exp %0d got %0d", $time, e.fix, m_fix_valid);
                    failed = 1'b1;
                end
                if (m_position_updated !== e.upd) begin
                    $display("%0t: updated exp %0d got %0d", $time, e.upd,
                             m_position_updated);
                    failed = 1'b1;
                end
                if (m_latitude !== e.lat) begin
                    $display("%0t: lat exp %0d got %0d", $time, e.lat, m_latitude);
                    failed = 1'b1;
                end
                if (m_longitude !== e.lon) begin
                    $display("%0t: lon exp %0d got %0d", $time, e.lon, m_longitude);
                    failed = 1'b1;
                end
                if (m_num_sats !== e.sats) begin
                    $display("%0t: sats exp %0d got %0d", $time, e.sats, m_num_sats);
                    failed = 1'b1;
                end
                if (m_altitude_dm !== e.alt) begin
                    $display("%0t: alt exp %0d got %0d", $time, e.alt, m_altitude_dm);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) byte_queue.push_back(s[i]);
    endtask

    function automatic string rand_num(int ip_digits, int fr_digits);
        string s;
        s = "";
        for (int i = 0; i < ip_digits; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        if (fr_digits > 0) begin
            s = {s, "."};
            for (int i = 0; i < fr_digits; i++)
                s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        end
        return s;
    endfunction

    function automatic string maybe(string s);
        return ($urandom_range(9) == 0) ? "" : s;
    endfunction

    task automatic put_random_line();
        int sel;
        string s;
        sel = $urandom_range(9);
        if (sel < 4) begin
            s = $sformatf("$GPRMC,%s,%s,%s,%s,%s,%s,0.1,0.0,010203,,,A*6A",
                rand_num(6, 2), maybe($urandom_range(4) ? "A" : "V"),
                maybe(rand_num($urandom_range(1, 5), $urandom_range(0, 8))),
                maybe($urandom_range(1) ? "S" : "N"),
                maybe({$urandom_range(5) ? "" : "-",
                       rand_num($urandom_range(1, 6), $urandom_range(0, 7))}),
                maybe($urandom_range(1) ? "W" : "E"));
        end else if (sel < 8) begin
            s = $sformatf("%s,%s,,,,,1,%s,0.9,%s,M,,M,,*47",
                $urandom_range(1) ? "$GPGGA" : "$GNGGA", rand_num(6, 2),
                maybe({$urandom_range(7) ? "" : "-", rand_num($urandom_range(1, 4), 0)}),
                maybe({$urandom_range(3) ? "" : "-",
                       rand_num($urandom_range(1, 7), $urandom_range(0, 3))}));
        end else begin
            s = "";
            repeat ($urandom_range(0, 20)) begin
                case ($urandom_range(3))
                    0: s = {s, ","};
                    1: s = {s, string'(8'($urandom_range(14, 255)))};
                    default: s = {s, string'(8'($urandom_range(32, 126)))};
                endcase
            end
        end
        put_text(s);
        if ($urandom_range(3) == 0) byte_queue.push_back(CH_CR);
        byte_queue.push_back(CH_LF);
    endtask

    task automatic drain();
        while (byte_queue.size() != 0 || report_queue.size() != 0) @(posedge aclk);
    endtask

    initial begin
        line_reset();
        h_lat = 0; h_lon = 0; h_alt = 0; h_sats = 0; h_fix = 0;
        pend_lat = 0; pend_lon = 0; pend_sats = 0; pend_alt = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // directed lines
        put_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\n");
        put_text("$GPRMC,1,A,9000.00000,S,18000.000009,W\n");
        put_text("$GPRMC,1,A,9999.99999,N,99999.99999,E\n");
        put_text("$GPRMC,1,A,-4807.1,S,-01131.5,W\n");
        put_text("$GPRMC,1,V,4807.0,N,01131.0,E\n");
        put_text("$GPRMC,1,A,,N,01131.0,E\n");
        put_text("$GPRMC,,,\n");
        put_text("$GPGGA,1,2,N,3,E,1,08,0.9,545.47,M\n");
        put_text("$GNGGA,1,2,N,3,E,1,999999999999,0.9,99999999.9,M\n");
        put_text("$GNGGA,1,2,N,3,E,1,-5,0.9,-99999999.9,M\n");
        put_text("$GPGGA,1,2,N,3,E,1,\t+12x,0.9, -12.345,M\n");
        put_text("$GPGGA,,,,,,,,,,\r\n");
        put_text("$GPG\n");
        put_text("\n");
        byte_queue.push_back(8'hFF);
        byte_queue.push_back(CH_NUL);
        put_text("$GPRMC\n");
        put_text("$GPRMC,1,A,1234.5");
        byte_queue.push_back(CH_NUL);
        put_text(",N,1,E\n");
        put_text("$GPRMC,1,A,4807.0,N,01131.0,E,");
        repeat (110) byte_queue.push_back(8'd49);
        put_text(",\n");
        put_text("$GPGGA");
        repeat (300) byte_queue.push_back(8'd55);
        put_text("$GPGGA,1,2,N,3,E,1,12,0.9,100.0,M\n");
        drain();
        // sender pauses with a line queued, then resumes
        hold_send = 1'b1;
        put_text("$GPRMC,1,A,0000.00001,N,00000.00001,W\n");
        repeat (40) @(posedge aclk);
        hold_send = 1'b0;
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 86 : 0;
            recv_idle_pct = (ph == 0) ? 86 : (ph == 1) ? 11 : 0;
            repeat (5) put_random_line();
            drain();
        end
        drain();
        repeat (50) @(posedge aclk);
        if (!failed && report_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
